// File: rtl/triple_sensor_voter_unit_macros.svh
// Assertion macros shared by the voter RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef TRIPLE_SENSOR_VOTER_UNIT_MACROS_SVH
`define TRIPLE_SENSOR_VOTER_UNIT_MACROS_SVH

// same-cycle implication
`define TSV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voter check failed");

// next-cycle implication
`define TSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voter check failed");

`endif

// File: rtl/tsv_pkg.sv
// Shared constants for the triple sensor voter.
// No dependencies.
`timescale 1ns / 1ps

package tsv_pkg;

  localparam int NSENS  = 3;
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 16;

  localparam logic [1:0] ST_UNCAL = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;
  localparam logic [1:0] ST_DRIFT = 2'd3;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CAL    = 1'b1;

  localparam logic [1:0] REG_FLOOR   = 2'd0;
  localparam logic [1:0] REG_CEILING = 2'd1;
  localparam logic [1:0] REG_DIV_ABS = 2'd2;
  localparam logic [1:0] REG_DIV_REL = 2'd3;

  localparam logic [1:0] NO_SENSOR = 2'd3;

  localparam logic [15:0] FLOOR_RST   = 16'd205;
  localparam logic [15:0] CEILING_RST = 16'd8192;
  localparam logic [15:0] DIV_ABS_RST = 16'd410;
  localparam logic [12:0] DIV_REL_RST = 13'd410;
  localparam logic [15:0] FACTOR_RST  = 16'd12186;

endpackage

// File: rtl/tsv_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tsv_pkg.
`timescale 1ns / 1ps

module tsv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tsv_pkg::DIV_NW-1:0] num,
  input  logic [tsv_pkg::DIV_DW-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [tsv_pkg::DIV_NW-1:0] quot
);

  localparam int NW  = tsv_pkg::DIV_NW;
  localparam int DW  = tsv_pkg::DIV_DW;
  localparam int CW  = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
        num_r <= {num_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = num_r;

endmodule

// File: rtl/triple_sensor_voter_unit.sv
// Triple oxygen sensor filter, plausibility check and voter: top level.
// Depends on tsv_pkg, tsv_div and triple_sensor_voter_unit_macros.svh.
//
//   channel | ports          | handshake
//   --------+----------------+-------------------------------
//   in      | in_*           | in_valid / in_stall
//   out     | out_*          | out_valid / out_stall
//   cfg     | psel..pready   | APB write, pready always high
//
// A sample request first updates the window; then, per sensor, a reciprocal
// multiply gives the window average and a serial division gives the pressure;
// then two divisions give the vote averages. A calibrate request takes one
// division; a failed vote ends early. All divisions run on the shared divider.
// The history memory has one valid bit per row, so reset needs no sweep.
// in_stall is high while a request is worked on; a finished result waits in
// the output register while the next request is accepted.
`timescale 1ns / 1ps
`include "triple_sensor_voter_unit_macros.svh"

module triple_sensor_voter_unit #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_sensor_a_millivolts,
  input  logic [15:0] in_sensor_b_millivolts,
  input  logic [15:0] in_sensor_c_millivolts,
  input  logic [1:0]  in_calibrate_index,
  input  logic [15:0] in_reference_pressure,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_voted_pressure,
  output logic [1:0]  out_voting_count,
  output logic        out_vote_valid,
  output logic        out_alarm_failed,
  output logic        out_alarm_divergent,
  output logic [1:0]  out_status_a,
  output logic [1:0]  out_status_b,
  output logic [1:0]  out_status_c,
  output logic [15:0] out_pressure_a,
  output logic [15:0] out_pressure_b,
  output logic [15:0] out_pressure_c,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH);
  localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int NW    = tsv_pkg::DIV_NW;
  localparam int DW    = tsv_pkg::DIV_DW;
  localparam int REC_SH = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] REC_M = (SUM_W + 1)'(((64'd1 << REC_SH) +
                                     64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_FGO, S_PGO, S_PW, S_V1, S_A1W,
    S_EXC, S_V2, S_A2W, S_CGO, S_CW, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] floor_r, ceil_r, dabs_r;
  logic [12:0] drel_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      tsv_pkg::REG_FLOOR:   prdata = 32'(floor_r);
      tsv_pkg::REG_CEILING: prdata = 32'(ceil_r);
      tsv_pkg::REG_DIV_ABS: prdata = 32'(dabs_r);
      tsv_pkg::REG_DIV_REL: prdata = 32'(drel_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= tsv_pkg::FLOOR_RST;
      ceil_r  <= tsv_pkg::CEILING_RST;
      dabs_r  <= tsv_pkg::DIV_ABS_RST;
      drel_r  <= tsv_pkg::DIV_REL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tsv_pkg::REG_FLOOR:   floor_r <= pwdata[15:0];
        tsv_pkg::REG_CEILING: ceil_r  <= pwdata[15:0];
        tsv_pkg::REG_DIV_ABS: dabs_r  <= pwdata[15:0];
        tsv_pkg::REG_DIV_REL: drel_r  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // sample history memory, one row of three readings per window slot
  logic [47:0]      hist_mem [WINDOW_DEPTH];
  logic [47:0]      hist_rd_r;
  logic             hist_vld_r [WINDOW_DEPTH];
  logic [POS_W-1:0] pos_r;
  logic             hist_we;
  logic [47:0]      hist_wd;

  always_ff @(posedge clk) begin
    hist_rd_r <= hist_mem[pos_r];
    if (hist_we) hist_mem[pos_r] <= hist_wd;
  end

  // per-sensor state
  logic [SUM_W-1:0] sum_r  [3];
  logic [15:0]      filt_r [3];
  logic [15:0]      fac_r  [3];
  logic [15:0]      pres_r [3];
  logic [1:0]       stat_r [3];
  logic             vote_r [3];

  logic [15:0] mv_r [3];
  logic [15:0] ref_r;
  logic [1:0]  idx_r;
  logic [15:0] avg_r;
  logic [15:0] last_vote_r;
  logic [1:0]  last_cnt_r;
  logic        fail_r, divg_r, item_ok_r;

  // divider
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [DW-1:0] div_den;
  logic [15:0]   div_sat;

  tsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  assign div_sat = (div_q[NW-1:16] != '0) ? 16'hFFFF : div_q[15:0];

  // window average by reciprocal multiply, exact for every window sum
  logic [PROD_W-1:0] filt_prod;
  assign filt_prod = PROD_W'(sum_r[idx_r]) * PROD_W'(REC_M);

  // voter sums
  logic [1:0]  vcnt;
  logic [17:0] vsum;
  assign vcnt = 2'(vote_r[0]) + 2'(vote_r[1]) + 2'(vote_r[2]);
  assign vsum = (vote_r[0] ? 18'(pres_r[0]) : 18'd0) + (vote_r[1] ? 18'(pres_r[1]) : 18'd0)
              + (vote_r[2] ? 18'(pres_r[2]) : 18'd0);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_PGO: begin
        div_start = 1'b1;
        div_num   = {filt_r[idx_r], 12'd0};
        div_den   = fac_r[idx_r];
      end
      S_V1, S_V2: begin
        div_start = (vcnt >= 2'd2);
        div_num   = NW'(vsum);
        div_den   = DW'(vcnt);
      end
      S_CGO: begin
        div_start = 1'b1;
        div_num   = {filt_r[idx_r], 12'd0};
        div_den   = ref_r;
      end
      default: ;
    endcase
  end

  // deviation test for the current sensor
  logic [15:0] dev;
  logic [28:0] rel_rhs;
  logic        excl;
  assign dev     = (pres_r[idx_r] > avg_r) ? pres_r[idx_r] - avg_r : avg_r - pres_r[idx_r];
  assign rel_rhs = 29'(avg_r) * 29'(drel_r);
  assign excl    = (dev > dabs_r) || ({1'b0, dev, 12'd0} > rel_rhs);

  // window update
  logic             row_vld;
  logic [15:0]      old_mv [3];
  logic [SUM_W-1:0] sum_new [3];
  assign row_vld = hist_vld_r[pos_r];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      old_mv[i]  = row_vld ? hist_rd_r[16*i +: 16] : 16'd0;
      sum_new[i] = sum_r[i] - SUM_W'(old_mv[i]) + SUM_W'(mv_r[i]);
    end
  end
  assign hist_we = (state_r == S_UPD);
  assign hist_wd = {mv_r[2], mv_r[1], mv_r[0]};

  logic in_acc, out_free;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      idx_r     <= '0;
      fail_r    <= 1'b0;
      divg_r    <= 1'b0;
      item_ok_r <= 1'b0;
      last_vote_r <= '0;
      last_cnt_r  <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) hist_vld_r[i] <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        filt_r[i] <= '0;
        fac_r[i]  <= tsv_pkg::FACTOR_RST;
        pres_r[i] <= '0;
        stat_r[i] <= tsv_pkg::ST_UNCAL;
        vote_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid && !out_stall && state_r != S_FIN) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            item_ok_r <= 1'b0;
            mv_r[0]   <= in_sensor_a_millivolts;
            mv_r[1]   <= in_sensor_b_millivolts;
            mv_r[2]   <= in_sensor_c_millivolts;
            ref_r     <= in_reference_pressure;
            if (in_req_type == tsv_pkg::REQ_SAMPLE) begin
              state_r <= S_UPD;
            end else begin
              idx_r <= in_calibrate_index;
              if (in_calibrate_index != tsv_pkg::NO_SENSOR &&
                  filt_r[in_calibrate_index] != 16'd0 && in_reference_pressure != 16'd0)
                state_r <= S_CGO;
              else
                state_r <= S_FIN;
            end
          end
        end
        S_UPD: begin
          for (int i = 0; i < 3; i++) sum_r[i] <= sum_new[i];
          hist_vld_r[pos_r] <= 1'b1;
          pos_r   <= (pos_r == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;
          idx_r   <= '0;
          state_r <= S_FGO;
        end
        S_FGO: begin
          filt_r[idx_r] <= filt_prod[REC_SH +: 16];
          state_r       <= S_PGO;
        end
        S_PGO: state_r <= S_PW;
        S_PW: begin
          if (div_done) begin
            pres_r[idx_r] <= div_sat;
            if (div_sat < floor_r || div_sat > ceil_r) begin
              stat_r[idx_r] <= tsv_pkg::ST_FAIL;
              vote_r[idx_r] <= 1'b0;
            end else if (stat_r[idx_r] != tsv_pkg::ST_FAIL) begin
              stat_r[idx_r] <= tsv_pkg::ST_OK;
              vote_r[idx_r] <= 1'b1;
            end
            if (idx_r == 2'd2) begin
              state_r <= S_V1;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_FGO;
            end
          end
        end
        S_V1: begin
          if (vcnt < 2'd2) begin
            fail_r  <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_A1W;
          end
        end
        S_A1W: begin
          if (div_done) begin
            avg_r   <= div_q[15:0];
            idx_r   <= '0;
            state_r <= S_EXC;
          end
        end
        S_EXC: begin
          if (vote_r[idx_r] && excl) begin
            vote_r[idx_r] <= 1'b0;
            stat_r[idx_r] <= tsv_pkg::ST_DRIFT;
          end
          if (idx_r == 2'd2) state_r <= S_V2;
          else idx_r <= idx_r + 1'b1;
        end
        S_V2: begin
          if (vcnt < 2'd2) begin
            fail_r  <= 1'b1;
            state_r <= S_FIN;
          end else begin
            last_cnt_r <= vcnt;
            state_r    <= S_A2W;
          end
        end
        S_A2W: begin
          if (div_done) begin
            last_vote_r <= div_q[15:0];
            divg_r      <= (last_cnt_r != 2'd3);
            item_ok_r   <= 1'b1;
            state_r     <= S_FIN;
          end
        end
        S_CGO: state_r <= S_CW;
        S_CW: begin
          if (div_done) begin
            fac_r[idx_r]  <= (div_sat == 16'd0) ? 16'd1 : div_sat;
            stat_r[idx_r] <= tsv_pkg::ST_OK;
            vote_r[idx_r] <= 1'b1;
            state_r       <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_voted_pressure  <= last_vote_r;
            out_voting_count    <= last_cnt_r;
            out_vote_valid      <= item_ok_r;
            out_alarm_failed    <= fail_r;
            out_alarm_divergent <= divg_r;
            out_status_a        <= stat_r[0];
            out_status_b        <= stat_r[1];
            out_status_c        <= stat_r[2];
            out_pressure_a      <= pres_r[0];
            out_pressure_b      <= pres_r[1];
            out_pressure_c      <= pres_r[2];
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TSV_ASSERT_NEXT(a_accept_busy, in_acc, state_r != S_IDLE)
  `TSV_ASSERT_NOW(a_div_idle_start, div_start, !div_busy)
  `TSV_ASSERT_NOW(a_vote_count, out_valid && out_vote_valid, out_voting_count >= 2'd2)
  `TSV_ASSERT_NOW(a_divergent, out_valid && out_vote_valid,
                  out_alarm_divergent == (out_voting_count != 2'd3))

endmodule

// File: verif/testbench.sv
// Self-checking testbench for triple_sensor_voter_unit: filtering, calibration,
// plausibility, exclusion and vote, predicted in SV and compared as one packed reading.
// Depends on tsv_pkg and the RTL of triple_sensor_voter_unit.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        kind;
    logic [15:0] mv_a, mv_b, mv_c;
    logic [1:0]  cal_idx;
    logic [15:0] ref_p;
  } request_t;

  typedef struct packed {
    logic [15:0] voted;
    logic [1:0]  count;
    logic        vvalid, afail, adiv;
    logic [1:0]  st_a, st_b, st_c;
    logic [15:0] pr_a, pr_b, pr_c;
  } reading_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic in_req_type = 0;
  logic [15:0] in_sensor_a_millivolts = 0, in_sensor_b_millivolts = 0;
  logic [15:0] in_sensor_c_millivolts = 0, in_reference_pressure = 0;
  logic [1:0] in_calibrate_index = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] out_voted_pressure, out_pressure_a, out_pressure_b, out_pressure_c;
  logic [1:0] out_voting_count, out_status_a, out_status_b, out_status_c;
  logic out_vote_valid, out_alarm_failed, out_alarm_divergent;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  triple_sensor_voter_unit uut (.*);

  always #10 clk = ~clk;

  // predictor state
  localparam int DEPTH = 8;
  logic [15:0] hist [3][DEPTH];
  logic [18:0] wsum [3];
  int unsigned wpos;
  logic [15:0] filt [3], factor [3], press [3];
  logic [1:0]  state [3];
  logic        votes [3];
  logic [15:0] last_vote;
  logic [1:0]  last_cnt;
  logic        fail_alarm, div_alarm;
  logic [15:0] lim_floor, lim_ceil, lim_abs;
  logic [12:0] lim_rel;

  request_t pending [$];
  reading_t expected [$];
  int errors = 0, accepted = 0, checked = 0, cal_count = 0, vote_count = 0;
  int send_idle = 0, recv_stall = 0, hold_off = 0;

  function automatic logic [15:0] sat_quot(logic [31:0] num, logic [31:0] den);
    logic [31:0] q;
    if (den == 0) return 16'hFFFF;
    q = num / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic int tally(output logic [31:0] total);
    int n = 0;
    total = 0;
    for (int i = 0; i < 3; i++)
      if (votes[i]) begin
        total += 32'(press[i]);
        n++;
      end
    return n;
  endfunction

  function automatic logic run_vote();
    logic [31:0] total, avg, dev;
    int n;
    n = tally(total);
    if (n < 2) begin
      fail_alarm = 1;
      return 0;
    end
    avg = total / 32'(n);
    for (int i = 0; i < 3; i++) begin
      if (!votes[i]) continue;
      dev = (32'(press[i]) > avg) ? 32'(press[i]) - avg : avg - 32'(press[i]);
      if (dev > 32'(lim_abs) || 64'(dev) * 64'd4096 > 64'(avg) * 64'(lim_rel)) begin
        votes[i] = 0;
        state[i] = tsv_pkg::ST_DRIFT;
      end
    end
    n = tally(total);
    if (n < 2) begin
      fail_alarm = 1;
      return 0;
    end
    last_vote = 16'(total / 32'(n));
    last_cnt = 2'(n);
    div_alarm = (n < 3);
    return 1;
  endfunction

  function automatic reading_t predict_reading(request_t r);
    reading_t o;
    logic ok = 0;
    logic [15:0] mv [3];
    logic [1:0] ix;
    logic [15:0] f;
    mv[0] = r.mv_a; mv[1] = r.mv_b; mv[2] = r.mv_c;
    if (r.kind == tsv_pkg::REQ_SAMPLE) begin
      for (int i = 0; i < 3; i++) begin
        wsum[i] = wsum[i] - 19'(hist[i][wpos]) + 19'(mv[i]);
        hist[i][wpos] = mv[i];
        filt[i] = 16'(wsum[i] / 19'(DEPTH));
        press[i] = sat_quot(32'({filt[i], 12'd0}), 32'(factor[i]));
        if (press[i] < lim_floor || press[i] > lim_ceil) begin
          state[i] = tsv_pkg::ST_FAIL;
          votes[i] = 0;
        end else if (state[i] != tsv_pkg::ST_FAIL) begin
          state[i] = tsv_pkg::ST_OK;
          votes[i] = 1;
        end
      end
      wpos = (wpos + 1) % DEPTH;
      ok = run_vote();
    end else begin
      ix = r.cal_idx;
      if (ix != tsv_pkg::NO_SENSOR && filt[ix] > 0 && r.ref_p > 0) begin
        f = sat_quot(32'({filt[ix], 12'd0}), 32'(r.ref_p));
        factor[ix] = (f < 1) ? 16'd1 : f;
        state[ix] = tsv_pkg::ST_OK;
        votes[ix] = 1;
      end
    end
    o.voted = last_vote; o.count = last_cnt; o.vvalid = ok;
    o.afail = fail_alarm; o.adiv = div_alarm;
    o.st_a = state[0]; o.st_b = state[1]; o.st_c = state[2];
    o.pr_a = press[0]; o.pr_b = press[1]; o.pr_c = press[2];
    return o;
  endfunction

  // driver
  logic in_stall_q;
  request_t cur;
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected.push_back(predict_reading(cur));
      accepted++;
      if (cur.kind == tsv_pkg::REQ_CAL) cal_count++;
    end
    in_stall_q <= in_valid && in_stall;
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && in_stall_q)) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur = pending.pop_front();
        in_valid <= 1;
        in_req_type <= cur.kind;
        in_sensor_a_millivolts <= cur.mv_a;
        in_sensor_b_millivolts <= cur.mv_b;
        in_sensor_c_millivolts <= cur.mv_c;
        in_calibrate_index <= cur.cal_idx;
        in_reference_pressure <= cur.ref_p;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_voted_pressure, out_voting_count, out_vote_valid, out_alarm_failed,
             out_alarm_divergent, out_status_a, out_status_b, out_status_c,
             out_pressure_a, out_pressure_b, out_pressure_c};
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp_r = expected.pop_front();
        checked++;
        if (exp_r.vvalid) vote_count++;
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          $display("  voted %0d/%0d cnt %0d/%0d valid %b/%b fail %b/%b div %b/%b",
                   exp_r.voted, got.voted, exp_r.count, got.count, exp_r.vvalid,
                   got.vvalid, exp_r.afail, got.afail, exp_r.adiv, got.adiv);
          $display("  status %h%h%h/%h%h%h pa %0d/%0d pb %0d/%0d pc %0d/%0d",
                   exp_r.st_a, exp_r.st_b, exp_r.st_c, got.st_a, got.st_b, got.st_c,
                   exp_r.pr_a, got.pr_a, exp_r.pr_b, got.pr_b, exp_r.pr_c, got.pr_c);
        end
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      tsv_pkg::REG_FLOOR:   lim_floor = val[15:0];
      tsv_pkg::REG_CEILING: lim_ceil = val[15:0];
      tsv_pkg::REG_DIV_ABS: lim_abs = val[15:0];
      default:              lim_rel = val[12:0];
    endcase
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic request_t sample_req(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    request_t r;
    r = '0;
    r.kind = tsv_pkg::REQ_SAMPLE; r.mv_a = a; r.mv_b = b; r.mv_c = c;
    r.cal_idx = 2'($urandom); r.ref_p = 16'($urandom);
    return r;
  endfunction

  function automatic request_t cal_req(logic [1:0] ix, logic [15:0] rp);
    request_t r;
    r = '0;
    r.kind = tsv_pkg::REQ_CAL; r.cal_idx = ix; r.ref_p = rp;
    r.mv_a = 16'($urandom); r.mv_b = 16'($urandom); r.mv_c = 16'($urandom);
    return r;
  endfunction

  // mostly consistent readings around a nominal value with an occasional outlier, mixed with calibrate requests
  task automatic random_items(int count);
    logic [15:0] base, a, b, c;
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      base = 16'($urandom_range(2000, 20000));
      a = 16'(32'(base) + $urandom_range(300) - 150);
      b = 16'(32'(base) + $urandom_range(300) - 150);
      c = 16'(32'(base) + $urandom_range(300) - 150);
      if (sel < 8) a = 16'($urandom);
      else if (sel < 12) c = 16'($urandom_range(3000));
      if (sel >= 85 && sel < 95)
        pending.push_back(cal_req(2'($urandom_range(3)), 16'($urandom_range(1, 8192))));
      else if (sel >= 95)
        pending.push_back(cal_req(2'($urandom), 16'($urandom)));
      else
        pending.push_back(sample_req(a, b, c));
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      wsum[i] = 0; filt[i] = 0; factor[i] = tsv_pkg::FACTOR_RST; press[i] = 0;
      state[i] = tsv_pkg::ST_UNCAL; votes[i] = 0;
      for (int j = 0; j < DEPTH; j++) hist[i][j] = 0;
    end
    wpos = 0; last_vote = 0; last_cnt = 0; fail_alarm = 0; div_alarm = 0;
    lim_floor = tsv_pkg::FLOOR_RST; lim_ceil = tsv_pkg::CEILING_RST;
    lim_abs = tsv_pkg::DIV_ABS_RST; lim_rel = tsv_pkg::DIV_REL_RST;
    in_stall_q = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // directed: zero window, calibration corner cases, extremes
    pending.push_back(cal_req(0, 4096));
    pending.push_back(sample_req(16'h0000, 16'h0000, 16'h0000));
    pending.push_back(cal_req(1, 0));
    for (int i = 0; i < 8; i++) pending.push_back(sample_req(9748, 9748, 9748));
    pending.push_back(sample_req(9748, 9748, 16'hFFFF));
    pending.push_back(sample_req(16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending.push_back(cal_req(tsv_pkg::NO_SENSOR, 4096));
    pending.push_back(cal_req(0, 16'hFFFF));
    pending.push_back(cal_req(1, 1));
    pending.push_back(cal_req(2, 4096));
    pending.push_back(sample_req(9748, 12000, 5000));
    pending.push_back(sample_req(1, 16'h8000, 16'h5555));
    pending.push_back(sample_req(16'hAAAA, 16'h7FFF, 0));
    pending.push_back(cal_req(0, 4096));
    pending.push_back(cal_req(1, 4096));
    pending.push_back(cal_req(2, 4096));
    drain();

    cfg_write(tsv_pkg::REG_FLOOR, 0); cfg_write(tsv_pkg::REG_CEILING, 16'hFFFF);
    cfg_write(tsv_pkg::REG_DIV_ABS, 16'hFFFF); cfg_write(tsv_pkg::REG_DIV_REL, 4096);
    random_items(150);
    drain();

    cfg_write(tsv_pkg::REG_FLOOR, 16'hFFFF); cfg_write(tsv_pkg::REG_CEILING, 0);
    cfg_write(tsv_pkg::REG_DIV_ABS, 0); cfg_write(tsv_pkg::REG_DIV_REL, 0);
    send_idle = 87;
    random_items(100);
    drain();

    cfg_write(tsv_pkg::REG_FLOOR, 100); cfg_write(tsv_pkg::REG_CEILING, 12000);
    cfg_write(tsv_pkg::REG_DIV_ABS, 600); cfg_write(tsv_pkg::REG_DIV_REL, 500);
    send_idle = 0; recv_stall = 87;
    random_items(150);
    drain();

    send_idle = 14; recv_stall = 14;
    cfg_write(tsv_pkg::REG_FLOOR, 32'(tsv_pkg::FLOOR_RST));
    cfg_write(tsv_pkg::REG_CEILING, 32'(tsv_pkg::CEILING_RST));
    cfg_write(tsv_pkg::REG_DIV_ABS, 32'(tsv_pkg::DIV_ABS_RST));
    cfg_write(tsv_pkg::REG_DIV_REL, 32'(tsv_pkg::DIV_REL_RST));
    random_items(250);
    drain();

    send_idle = 0; recv_stall = 0; hold_off = 3000;
    random_items(200);
    drain();

    $display("tb: %0d requests (%0d calibrate), %0d results checked, %0d valid votes",
             accepted, cal_count, checked, vote_count);
    $display("tb: five register settings, idle/stall phases and one long output hold");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
